// ===== sv/rrf_pkg.sv =====
// Package for the renaming register file: field widths and the beat layout
// of one input item. No dependencies.
package rrf_pkg;

	// Fixed field widths of the item and result ports
	localparam int IDX_W = 5;
	localparam int TAG_W = 5;
	localparam int IN_W  = 32;
	localparam int OUT_W = 32;

	// One accepted input beat, held in the read stage
	typedef struct packed {
		logic             commit_valid;
		logic [IDX_W-1:0] commit_rd;
		logic [IN_W-1:0]  commit_value;
		logic [TAG_W-1:0] commit_tag;
		logic             rename_valid;
		logic [IDX_W-1:0] rename_rd;
		logic [TAG_W-1:0] rename_tag;
		logic             flush;
		logic [IDX_W-1:0] src1_index;
		logic [IDX_W-1:0] src2_index;
	} item_t;

endpackage

// ===== sv/rrf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port; read returns the old contents on a same-edge collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/renaming_register_file_top.sv =====
// Renaming register file top level: value and tag RAMs, busy flags, read stage
// and output register. Depends on rrf_pkg and rrf_ram.
//
// The block takes one item per clock while the output is not stalled. The accept
// edge reads the value and tag RAMs, and the edge on which the item advances
// updates the state and loads the result into the output register, raising
// out_valid. A write-back forwarding register covers an item whose read
// coincides with the previous item's write, so the rate stays at one per cycle
// while the output is taken. Busy flags and the written marks for the value
// store are flip-flops cleared by reset, so no clearing pass is needed; flush
// clears every busy flag at once. Register x0 reads zero and is never busy.
module renaming_register_file_top
	import rrf_pkg::*;
#(
	parameter int NUM_REGS   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             commit_valid,
	input  logic [IDX_W-1:0] commit_rd,
	input  logic [IN_W-1:0]  commit_value,
	input  logic [TAG_W-1:0] commit_tag,
	input  logic             rename_valid,
	input  logic [IDX_W-1:0] rename_rd,
	input  logic [TAG_W-1:0] rename_tag,
	input  logic             flush,
	input  logic [IDX_W-1:0] src1_index,
	input  logic [IDX_W-1:0] src2_index,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [OUT_W-1:0] src1_value,
	output logic             src1_busy,
	output logic [TAG_W-1:0] src1_tag,
	output logic [OUT_W-1:0] src2_value,
	output logic             src2_busy,
	output logic [TAG_W-1:0] src2_tag
);

	localparam int AW = $clog2(NUM_REGS);
	localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int EW = (DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W;

	// Map a register index to a RAM address
	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [XW-1:0] w;
		w = XW'(idx);
		return w[AW-1:0];
	endfunction

	// Index names a real register other than x0
	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		logic [XW-1:0] w;
		w = XW'(idx);
		return (w != '0) && (w < XW'(NUM_REGS));
	endfunction

	// Handshake and stage control
	logic accept;
	logic adv;
	logic valid_s1;
	item_t item_s1;
	logic out_valid_q;

	// State outside the RAMs
	logic [NUM_REGS-1:0] busy_q;
	logic [NUM_REGS-1:0] written_q;

	// Forwarding of the write that lands on the same edge as a read
	logic                  fv_en_q;
	logic [AW-1:0]         fv_addr_q;
	logic [DATA_WIDTH-1:0] fv_data_q;
	logic                  ft_en_q;
	logic [AW-1:0]         ft_addr_q;
	logic [TAG_W-1:0]      ft_data_q;

	// RAM read data
	logic [DATA_WIDTH-1:0] ram_val [2];
	logic [TAG_W-1:0]      ram_tag [2];
	logic [TAG_W-1:0]      ram_tag_c;

	// Stage-1 decode
	logic [EW-1:0]         cv_ext;
	logic [DATA_WIDTH-1:0] cval;
	logic [AW-1:0]         c_addr;
	logic [AW-1:0]         r_addr;
	logic                  val_we;
	logic                  tag_we;
	logic [TAG_W-1:0]      c_stored_tag;
	logic                  c_clear;

	// Per-source results
	logic [IDX_W-1:0] src_idx [2];
	logic [OUT_W-1:0] res_val [2];
	logic             res_busy [2];
	logic [TAG_W-1:0] res_tag [2];

	// Output register
	logic [OUT_W-1:0] src1_value_q, src2_value_q;
	logic             src1_busy_q, src2_busy_q;
	logic [TAG_W-1:0] src1_tag_q, src2_tag_q;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	// Hold the accepted beat in the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.commit_valid <= commit_valid;
			item_s1.commit_rd    <= commit_rd;
			item_s1.commit_value <= commit_value;
			item_s1.commit_tag   <= commit_tag;
			item_s1.rename_valid <= rename_valid;
			item_s1.rename_rd    <= rename_rd;
			item_s1.rename_tag   <= rename_tag;
			item_s1.flush        <= flush;
			item_s1.src1_index   <= src1_index;
			item_s1.src2_index   <= src2_index;
		end
	end

	// Decode the writes of the item in the read stage
	always_comb begin
		cv_ext       = EW'(item_s1.commit_value);
		cval         = cv_ext[DATA_WIDTH-1:0];
		c_addr       = to_addr(item_s1.commit_rd);
		r_addr       = to_addr(item_s1.rename_rd);
		val_we       = !item_s1.flush && item_s1.commit_valid && in_range(item_s1.commit_rd);
		tag_we       = !item_s1.flush && item_s1.rename_valid && in_range(item_s1.rename_rd);
		c_stored_tag = (ft_en_q && ft_addr_q == c_addr) ? ft_data_q : ram_tag_c;
		c_clear      = val_we && busy_q[c_addr] && (c_stored_tag == item_s1.commit_tag);
	end

	// Value store, one copy per source port
	rrf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_val_a (
		.clk(clk), .we(adv && val_we), .waddr(c_addr), .wdata(cval),
		.re(accept), .raddr(to_addr(src1_index)), .rdata(ram_val[0])
	);
	rrf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_val_b (
		.clk(clk), .we(adv && val_we), .waddr(c_addr), .wdata(cval),
		.re(accept), .raddr(to_addr(src2_index)), .rdata(ram_val[1])
	);

	// Tag store, one copy per source port and one for the commit match
	rrf_ram #(.WIDTH(TAG_W), .DEPTH(NUM_REGS)) u_tag_a (
		.clk(clk), .we(adv && tag_we), .waddr(r_addr), .wdata(item_s1.rename_tag),
		.re(accept), .raddr(to_addr(src1_index)), .rdata(ram_tag[0])
	);
	rrf_ram #(.WIDTH(TAG_W), .DEPTH(NUM_REGS)) u_tag_b (
		.clk(clk), .we(adv && tag_we), .waddr(r_addr), .wdata(item_s1.rename_tag),
		.re(accept), .raddr(to_addr(src2_index)), .rdata(ram_tag[1])
	);
	rrf_ram #(.WIDTH(TAG_W), .DEPTH(NUM_REGS)) u_tag_c (
		.clk(clk), .we(adv && tag_we), .waddr(r_addr), .wdata(item_s1.rename_tag),
		.re(accept), .raddr(to_addr(commit_rd)), .rdata(ram_tag_c)
	);

	// Capture the write that coincides with the next read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_en_q <= 1'b0;
			ft_en_q <= 1'b0;
		end else if (accept) begin
			fv_en_q <= adv && val_we;
			ft_en_q <= adv && tag_we;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fv_addr_q <= c_addr;
			fv_data_q <= cval;
			ft_addr_q <= r_addr;
			ft_data_q <= item_s1.rename_tag;
		end
	end

	// Update busy flags and written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			written_q <= '0;
		end else if (adv) begin
			if (item_s1.flush) begin
				busy_q <= '0;
			end else begin
				if (c_clear) begin
					busy_q[c_addr] <= 1'b0;
				end
				if (tag_we) begin
					busy_q[r_addr] <= 1'b1;
				end
				if (val_we) begin
					written_q[c_addr] <= 1'b1;
				end
			end
		end
	end

	// Resolve each source: stored state, commit bypass, rename override
	assign src_idx[0] = item_s1.src1_index;
	assign src_idx[1] = item_s1.src2_index;

	always_comb begin
		logic [AW-1:0]         a;
		logic [DATA_WIDTH-1:0] v;
		logic [EW-1:0]         v_ext;
		logic                  b;
		logic [TAG_W-1:0]      t;
		for (int s = 0; s < 2; s++) begin
			a = to_addr(src_idx[s]);
			v = '0;
			b = 1'b0;
			t = '0;
			if (src_idx[s] != '0) begin
				if (in_range(src_idx[s])) begin
					if (fv_en_q && fv_addr_q == a) begin
						v = fv_data_q;
					end else if (written_q[a]) begin
						v = ram_val[s];
					end
					b = busy_q[a];
					t = (ft_en_q && ft_addr_q == a) ? ft_data_q : ram_tag[s];
				end
				if (item_s1.commit_valid && item_s1.commit_rd == src_idx[s]) begin
					v = cval;
					if (b && t == item_s1.commit_tag) begin
						b = 1'b0;
					end
				end
				if (item_s1.rename_valid && item_s1.rename_rd == src_idx[s]) begin
					b = 1'b1;
					t = item_s1.rename_tag;
				end
				if (!b) begin
					t = '0;
				end
			end
			v_ext       = EW'(v);
			res_val[s]  = v_ext[OUT_W-1:0];
			res_busy[s] = b;
			res_tag[s]  = t;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src1_value_q <= res_val[0];
			src1_busy_q  <= res_busy[0];
			src1_tag_q   <= res_tag[0];
			src2_value_q <= res_val[1];
			src2_busy_q  <= res_busy[1];
			src2_tag_q   <= res_tag[1];
		end
	end

	assign out_valid  = out_valid_q;
	assign src1_value = src1_value_q;
	assign src1_busy  = src1_busy_q;
	assign src1_tag   = src1_tag_q;
	assign src2_value = src2_value_q;
	assign src2_busy  = src2_busy_q;
	assign src2_tag   = src2_tag_q;

	// x0 never becomes busy
	a_x0_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q[0])
		else $error("register x0 marked busy");

	// Flush leaves no busy flag behind
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.flush |=> busy_q == '0)
		else $error("busy flag survived a flush");

	// A rename that goes through marks its destination busy
	a_rename_sets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && tag_we |=> busy_q[$past(r_addr)])
		else $error("renamed register not busy");

	// Input stalls only while the read stage is occupied
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty read stage");

endmodule
